>>> hdl/mciir_pkg.sv
package mciir_pkg;

    // Filter shape
    localparam int ORDER    = 2;
    localparam int CHANNELS = 2;

    // Word widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int STATE_W    = 40;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = STATE_W + 1;
    localparam int FRAC_SHIFT = 16;
    localparam int SAMPLE_MAX = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAMPLE_MIN = -(2 ** (SAMPLE_W - 1));

    // Delay state store
    localparam int Z_DEPTH = ORDER * CHANNELS;
    localparam int Z_AW    = (Z_DEPTH > 1) ? $clog2(Z_DEPTH) : 1;
    localparam int N_W     = $clog2(ORDER + 1);

    // Configuration registers
    localparam int REG_IDX_W = 3;
    localparam int FF_NUM    = 4;
    localparam int FB_NUM    = 3;
    localparam logic [REG_IDX_W-1:0] REG_FF0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FF1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FF2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FF3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FB1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FB2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FB3 = 3'd6;
    localparam int FF0_RESET = 65536;

    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Microcode
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_MUL_B0  = 3'd0;
    localparam logic [PC_W-1:0] PC_ACC_Z0  = 3'd1;
    localparam logic [PC_W-1:0] PC_MAKE_Y  = 3'd2;
    localparam logic [PC_W-1:0] PC_LOOP    = 3'd3;
    localparam logic [PC_W-1:0] PC_MUL_AN  = 3'd4;
    localparam logic [PC_W-1:0] PC_WR_Z    = 3'd5;
    localparam logic [PC_W-1:0] PC_DONE    = 3'd6;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_PZ0,
        ACC_PZN
    } t_acc_op;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_DONE
    } t_jmp;

    typedef struct packed {
        logic    coef_fb;   // coefficient from the feedback bank
        logic    coef_n;    // coefficient index is the loop count, else zero
        logic    opnd_y;    // multiply by the output sample, else the input
        t_acc_op acc_op;
        logic    make_y;    // round and clip the accumulator into y
        logic    wr_z;      // write acc - product to the lower state
        t_jmp    jmp;
    } t_uword;

    typedef struct packed {
        t_uword         uw;
        logic [N_W-1:0] n;
        logic           done;
    } t_ctl;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            PC_MUL_B0: begin
                w.jmp = JMP_NEXT;
            end
            PC_ACC_Z0: begin
                w.acc_op = ACC_PZ0;
            end
            PC_MAKE_Y: begin
                w.make_y = 1'b1;
            end
            PC_LOOP: begin
                w.coef_n = 1'b1;
            end
            PC_MUL_AN: begin
                w.coef_fb = 1'b1;
                w.coef_n  = 1'b1;
                w.opnd_y  = 1'b1;
                w.acc_op  = ACC_PZN;
            end
            PC_WR_Z: begin
                w.wr_z = 1'b1;
                w.jmp  = JMP_LOOP;
            end
            PC_DONE: begin
                w.jmp = JMP_DONE;
            end
            default: begin
                w.jmp = JMP_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/multichannel_iir_filter_top.sv
// Multichannel IIR filter, transposed direct form II, two channels of
// second order. Each input word carries one Q1.15 sample and its channel;
// the block returns one Q1.15 output word per input, rounded half up and
// clipped, with a flag when clipping occurred. Each channel keeps its own
// 40-bit delay states; the clear flag on an input word zeroes all states
// of all channels before that word is filtered. Coefficients are Q2.16,
// already normalized by a0, and are written through the config channel
// (index 0..3 = b0..b3, 4..6 = a1..a3); the user must write them only while
// the block is idle; the block does not enforce it. Indexes above six are
// ignored. One 18x16 multiplier is shared by all products and a small
// microcode program in a ROM steps it, three program steps per filter
// section; a new word is not accepted before the previous word's program ends.
// The finished result sits in an output register, so the next word is
// accepted while the previous result still waits downstream. A word with
// an out-of-range channel returns zero; only its clear flag touches state.
module multichannel_iir_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample
    input  logic [1:0]  i_s_axis_tuser,   // [0] channel, [1] clear_state
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] filtered_sample
    output logic [0:0]  o_m_axis_tuser,   // [0] saturated
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mciir_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [mciir_pkg::COEF_W-1:0]    i_cfg_data
);
    import mciir_pkg::*;

    t_coef   r_ff [FF_NUM];
    t_coef   r_fb [FB_NUM];
    logic    r_oval;
    t_sample r_odata;
    logic    r_osat;

    logic    s_accept, cfg_we, ch_ok, out_free, seq_ready;
    t_ctl    ctl;
    t_sample dp_y;
    logic    dp_sat;

    assign s_accept = i_s_axis_tvalid && seq_ready;
    assign cfg_we   = i_cfg_valid;
    assign ch_ok    = int'(i_s_axis_tuser[0]) < CHANNELS;
    assign out_free = !r_oval || i_m_axis_tready;

    // Coefficient registers; write them only while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff[0] <= COEF_W'(FF0_RESET);
            for (int i = 1; i < FF_NUM; i++) r_ff[i] <= '0;
            for (int i = 0; i < FB_NUM; i++) r_fb[i] <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_FF0: r_ff[0] <= i_cfg_data;
                REG_FF1: r_ff[1] <= i_cfg_data;
                REG_FF2: r_ff[2] <= i_cfg_data;
                REG_FF3: r_ff[3] <= i_cfg_data;
                REG_FB1: r_fb[0] <= i_cfg_data;
                REG_FB2: r_fb[1] <= i_cfg_data;
                REG_FB3: r_fb[2] <= i_cfg_data;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Step through the program once per accepted word
    mciir_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept),
        .i_skip     (!ch_ok),
        .i_out_free (out_free),
        .o_ready    (seq_ready),
        .o_ctl      (ctl)
    );

    // Shared multiplier, accumulator and delay states
    mciir_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s_accept),
        .i_clear   (i_s_axis_tuser[1]),
        .i_skip    (!ch_ok),
        .i_sample  (i_s_axis_tdata),
        .i_channel (i_s_axis_tuser[0]),
        .i_ff      (r_ff),
        .i_fb      (r_fb),
        .i_ctl     (ctl),
        .o_y       (dp_y),
        .o_sat     (dp_sat)
    );

    // Output register: load on program end, hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (ctl.done) begin
            r_oval <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.done) begin
            r_odata <= dp_y;
            r_osat  <= dp_sat;
        end
    end

    assign o_s_axis_tready   = seq_ready;
    assign o_cfg_ready       = 1'b1;
    assign o_m_axis_tvalid   = r_oval;
    assign o_m_axis_tdata    = r_odata;
    assign o_m_axis_tuser[0] = r_osat;

    // A finished result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.done |-> (!r_oval || i_m_axis_tready))
        else $error("result overwrote an untaken output word");

    // A result leaves the program on the edge after it is finished
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.done |=> o_m_axis_tvalid)
        else $error("finished result not presented");

    // State writes address a section that exists
    a_wr_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.uw.wr_z |-> (int'(ctl.n) >= 1 && int'(ctl.n) <= ORDER))
        else $error("state write outside the filter sections");

    // An accepted word with a valid channel leaves the block not ready in the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && ch_ok) |=> !o_s_axis_tready)
        else $error("block ready again right after accepting a word");

endmodule

>>> hdl/mciir_seq.sv
module mciir_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_skip,
    input  logic               i_out_free,
    output logic               o_ready,
    output mciir_pkg::t_ctl    o_ctl
);
    import mciir_pkg::*;

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [N_W-1:0]  r_n, n_n;
    t_uword          uw;
    logic            done;

    assign uw   = ucode(r_pc);
    assign done = r_busy && (uw.jmp == JMP_DONE) && i_out_free;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_n    = r_n;
        if (!r_busy || done) begin
            n_busy = i_start;
            if (i_start) begin
                n_pc = i_skip ? PC_DONE : PC_MUL_B0;
                n_n  = N_W'(1);
            end
        end else begin
            case (uw.jmp)
                JMP_NEXT: n_pc = r_pc + 1'b1;
                JMP_LOOP: begin
                    if (int'(r_n) < ORDER) begin
                        n_n  = r_n + 1'b1;
                        n_pc = PC_LOOP;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
                default: n_pc = r_pc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_MUL_B0;
            r_n    <= N_W'(1);
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_n    <= n_n;
        end
    end

    assign o_ready    = !r_busy || done;
    assign o_ctl.uw   = r_busy ? uw : '0;
    assign o_ctl.n    = r_n;
    assign o_ctl.done = done;

endmodule

>>> hdl/mciir_dp.sv
module mciir_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_clear,
    input  logic               i_skip,
    input  mciir_pkg::t_sample i_sample,
    input  logic               i_channel,
    input  mciir_pkg::t_coef   i_ff [mciir_pkg::FF_NUM],
    input  mciir_pkg::t_coef   i_fb [mciir_pkg::FB_NUM],
    input  mciir_pkg::t_ctl    i_ctl,
    output mciir_pkg::t_sample o_y,
    output logic               o_sat
);
    import mciir_pkg::*;

    localparam int Q_W = ACC_W + 1 - FRAC_SHIFT;

    t_sample                     r_x, r_y;
    logic                        r_ch, r_sat, r_skip;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [STATE_W-1:0]   r_z [Z_DEPTH];

    logic [1:0]                  coef_idx;
    t_coef                       coef;
    t_sample                     opnd;
    logic [Z_AW-1:0]             rd_addr, wr_addr;
    logic signed [STATE_W-1:0]   z_rd;
    logic signed [ACC_W:0]       rnd;
    logic signed [Q_W-1:0]       q;
    logic                        q_hi, q_lo;
    logic signed [ACC_W-1:0]     diff;
    logic signed [STATE_W-1:0]   z_new;

    // Operand select for the shared multiplier
    assign coef_idx = i_ctl.uw.coef_n ? 2'(i_ctl.n) : 2'd0;
    assign coef     = i_ctl.uw.coef_fb ? i_fb[2'(coef_idx - 2'd1)] : i_ff[coef_idx];
    assign opnd     = i_ctl.uw.opnd_y ? r_y : r_x;

    // One read port into the state store
    assign rd_addr = (i_ctl.uw.acc_op == ACC_PZN)
                   ? Z_AW'(int'(i_ctl.n) * CHANNELS + int'(r_ch))
                   : Z_AW'(r_ch);
    assign wr_addr = Z_AW'((int'(i_ctl.n) - 1) * CHANNELS + int'(r_ch));
    assign z_rd    = ((i_ctl.uw.acc_op == ACC_PZN) && (int'(i_ctl.n) >= ORDER))
                   ? '0 : r_z[rd_addr];

    // Round half up, then clip to the sample range
    assign rnd  = (ACC_W+1)'(r_acc) + (ACC_W+1)'(2 ** (FRAC_SHIFT - 1));
    assign q    = rnd[ACC_W:FRAC_SHIFT];
    assign q_hi = q > Q_W'(SAMPLE_MAX);
    assign q_lo = q < Q_W'(SAMPLE_MIN);

    // New state value, clipped to the state width
    assign diff  = r_acc - ACC_W'(r_prod);
    assign z_new = (diff[ACC_W-1] != diff[ACC_W-2])
                 ? {diff[ACC_W-1], {(STATE_W-1){~diff[ACC_W-1]}}}
                 : diff[STATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x    <= i_sample;
            r_ch   <= i_channel;
            r_skip <= i_skip;
        end
        r_prod <= coef * opnd;
        case (i_ctl.uw.acc_op) inside
            ACC_PZ0, ACC_PZN: r_acc <= ACC_W'(r_prod) + ACC_W'(z_rd);
            default:          r_acc <= r_acc;
        endcase
        if (i_ctl.uw.make_y) begin
            r_sat <= q_hi || q_lo;
            if (q_hi) begin
                r_y <= SAMPLE_W'(SAMPLE_MAX);
            end else if (q_lo) begin
                r_y <= SAMPLE_W'(SAMPLE_MIN);
            end else begin
                r_y <= q[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Z_DEPTH; i++) r_z[i] <= '0;
        end else if (i_load && i_clear) begin
            for (int i = 0; i < Z_DEPTH; i++) r_z[i] <= '0;
        end else if (i_ctl.uw.wr_z) begin
            r_z[wr_addr] <= z_new;
        end
    end

    assign o_y   = r_skip ? '0 : r_y;
    assign o_sat = r_skip ? 1'b0 : r_sat;

endmodule
